// ===== hdl/sorted_priority_queue_defines.svh =====
// Assertion macros used by the sorted priority queue engine.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SPQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spq: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spq: next-cycle check failed");

`endif

// ===== hdl/spq_pkg.sv =====
// Shared types, codes and constants of the sorted priority queue.
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam int KEY_W     = 16;
  localparam int PAYLOAD_W = 32;
  localparam int CMD_W     = 3;
  localparam int INDEX_W   = 4;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 4;
  localparam int SIZE_W    = 5;

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_OFFER   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POLL    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MATCH   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DROP_AT = 3'd5;

  // Status codes on the output channel
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

  typedef enum logic [2:0] {
    OP_OFFER,
    OP_PEEK,
    OP_POLL,
    OP_READ,
    OP_MATCH,
    OP_DROP_AT,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    op_t                op;
    entry_t             entry;
    logic [INDEX_W-1:0] idx;
  } cmd_t;

endpackage

// ===== hdl/spq_front.sv =====
// Front end: accepts input transactions and decodes them into queue operations.
module spq_front import spq_pkg::*; (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     command,
  input  logic [KEY_W-1:0]     entry_key,
  input  logic [PAYLOAD_W-1:0] entry_payload,
  input  logic [INDEX_W-1:0]   position_index,
  output logic                 push_valid,
  input  logic                 push_ready,
  output cmd_t                 push_cmd
);

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  always_comb begin
    push_cmd.entry.key     = entry_key;
    push_cmd.entry.payload = entry_payload;
    push_cmd.idx           = position_index;
    unique case (command)
      CMD_OFFER:   push_cmd.op = OP_OFFER;
      CMD_PEEK:    push_cmd.op = OP_PEEK;
      CMD_POLL:    push_cmd.op = OP_POLL;
      CMD_READ:    push_cmd.op = OP_READ;
      CMD_MATCH:   push_cmd.op = OP_MATCH;
      CMD_DROP_AT: push_cmd.op = OP_DROP_AT;
      default:     push_cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== hdl/spq_fifo.sv =====
// Short command queue between the front end and the execution engine.
module spq_fifo import spq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          push;
  logic          pop;

  assign push_ready = (fill != FW'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/spq_back.sv =====
// Execution engine: entry memory, ascending scan sequencer and result register.
`include "sorted_priority_queue_defines.svh"

module spq_back import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 order_descending,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  cmd_t                 pop_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic [KEY_W-1:0]     result_key,
  output logic [PAYLOAD_W-1:0] result_payload,
  output logic [POS_W-1:0]     insert_position,
  output logic [SIZE_W-1:0]    removed_count,
  output logic [SIZE_W-1:0]    queue_size
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_RESULT
  } state_t;

  state_t              state;
  op_t                 op_r;
  logic [KEY_W-1:0]    op_key;
  logic [IW-1:0]       tgt;
  logic [CW-1:0]       count;
  logic [CW-1:0]       rd_addr;
  logic [CW-1:0]       rd_end;
  logic                rd_vld;
  logic [IW-1:0]       rd_idx;
  logic [CW-1:0]       wr_ptr;
  entry_t              carry;
  logic                ins_done;
  logic [IW-1:0]       ipos;
  logic [CW-1:0]       removed;
  entry_t              res;
  logic [STATUS_W-1:0] status_r;

  entry_t        mem [DEPTH];
  entry_t        mem_rdata;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;

  logic          goes_after;
  logic          in_range;
  logic [CW-1:0] idx_c;

  logic [STATUS_W-1:0] start_status;
  logic                start_scan;
  logic [CW-1:0]       start_addr;
  logic [CW-1:0]       start_end;
  logic                scan_overlap;

  assign pop_ready  = (state == S_IDLE);
  assign goes_after = order_descending ? (op_key < mem_rdata.key)
                                       : (op_key > mem_rdata.key);
  assign in_range   = (XW'(pop_cmd.idx) < XW'(count));
  assign idx_c      = CW'(pop_cmd.idx);

  // Classify the command at the queue head: scan range or immediate status
  always_comb begin
    start_status = STAT_OK;
    start_scan   = 1'b1;
    start_addr   = '0;
    start_end    = count;
    case (pop_cmd.op) inside
      OP_OFFER: begin
        if (count == CW'(DEPTH)) begin
          start_status = STAT_FULL;
          start_scan   = 1'b0;
        end
      end
      OP_PEEK, OP_POLL: begin
        if (count == '0) begin
          start_status = STAT_EMPTY;
          start_scan   = 1'b0;
        end else if (pop_cmd.op == OP_PEEK) begin
          start_end = CW'(1);
        end
      end
      OP_READ, OP_DROP_AT: begin
        if (!in_range) begin
          start_status = STAT_RANGE;
          start_scan   = 1'b0;
        end else begin
          start_addr = idx_c;
          if (pop_cmd.op == OP_READ) begin
            start_end = idx_c + 1'b1;
          end
        end
      end
      OP_MATCH: ;
      default: start_scan = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    mem_rdata <= mem[rd_addr[IW-1:0]];
  end

  // Writes trail the reads: an entry goes back at or below the index just read
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_idx;
    mem_wdata = carry;
    if (state == S_SCAN && rd_vld) begin
      case (op_r) inside
        OP_OFFER: begin
          if (ins_done || !goes_after) begin
            mem_we    = 1'b1;
            mem_waddr = rd_idx;
            mem_wdata = carry;
          end
        end
        OP_POLL, OP_DROP_AT: begin
          if (rd_idx != tgt) begin
            mem_we    = 1'b1;
            mem_waddr = rd_idx - 1'b1;
            mem_wdata = mem_rdata;
          end
        end
        OP_MATCH: begin
          if (mem_rdata.key != op_key) begin
            mem_we    = 1'b1;
            mem_waddr = wr_ptr[IW-1:0];
            mem_wdata = mem_rdata;
          end
        end
        default: ;
      endcase
    end else if (state == S_FINISH && op_r == OP_OFFER) begin
      mem_we    = 1'b1;
      mem_waddr = count[IW-1:0];
      mem_wdata = carry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            op_r     <= pop_cmd.op;
            op_key   <= pop_cmd.entry.key;
            carry    <= pop_cmd.entry;
            rd_vld   <= 1'b0;
            ins_done <= 1'b0;
            wr_ptr   <= '0;
            removed  <= '0;
            ipos     <= '0;
            res      <= '0;
            tgt      <= start_addr[IW-1:0];
            rd_addr  <= start_addr;
            rd_end   <= start_end;
            status_r <= start_status;
            state    <= start_scan ? S_SCAN : S_RESULT;
          end
        end

        S_SCAN: begin
          // Issue the next read while the previous one returns
          if (rd_addr < rd_end) begin
            rd_vld  <= 1'b1;
            rd_idx  <= rd_addr[IW-1:0];
            rd_addr <= rd_addr + 1'b1;
          end else begin
            rd_vld <= 1'b0;
            if (!rd_vld) begin
              state <= S_FINISH;
            end
          end
          if (rd_vld) begin
            case (op_r) inside
              OP_OFFER: begin
                if (ins_done || !goes_after) begin
                  carry    <= mem_rdata;
                  ins_done <= 1'b1;
                  if (!ins_done) begin
                    ipos <= rd_idx;
                  end
                end
              end
              OP_PEEK, OP_READ, OP_POLL, OP_DROP_AT: begin
                if (rd_idx == tgt) begin
                  res <= mem_rdata;
                end
              end
              OP_MATCH: begin
                if (mem_rdata.key == op_key) begin
                  removed <= removed + 1'b1;
                end else begin
                  wr_ptr <= wr_ptr + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end

        S_FINISH: begin
          case (op_r) inside
            OP_OFFER: begin
              if (!ins_done) begin
                ipos <= count[IW-1:0];
              end
              count <= count + 1'b1;
            end
            OP_POLL, OP_DROP_AT: count <= count - 1'b1;
            OP_MATCH:            count <= wr_ptr;
            default: ;
          endcase
          state <= S_RESULT;
        end

        S_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            status          <= status_r;
            result_key      <= res.key;
            result_payload  <= res.payload;
            insert_position <= POS_W'(ipos);
            removed_count   <= SIZE_W'(removed);
            queue_size      <= SIZE_W'(count);
            state           <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign scan_overlap = (state == S_SCAN) && mem_we && (rd_addr < rd_end);

  `SPQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `SPQ_ASSERT_NOW(a_write_below_fill, clk, rst, mem_we, CW'(mem_waddr) <= count)
  `SPQ_ASSERT_NOW(a_no_read_write_clash, clk, rst, scan_overlap, mem_waddr != rd_addr[IW-1:0])
  `SPQ_ASSERT_NEXT(a_count_only_at_finish, clk, rst, state != S_FINISH, $stable(count))

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: front end, command queue, engine, config.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command transaction: command,
//   entry_key, entry_payload and position_index. Output channel
//   (out_valid/out_ready) returns exactly one result transaction per command,
//   in command order: status, result_key, result_payload, insert_position,
//   removed_count and queue_size (size after the command).
//   Config channel (cfg_valid/cfg_ready) writes order_descending; write it only
//   while no command is outstanding. cfg_ready is always high.
// Timing:
//   Entries live in a single-port-write memory and every command that is neither
//   refused nor unknown is one ascending scan over it, at one read per cycle.
//   Offer, poll and remove-matching scan every held entry, remove-at scans from
//   its index on, peek and read-at read one entry, refused commands skip the scan.
//   A two-entry command queue holds in_ready high for a busy engine until it fills.
// Reset:
//   rst (synchronous, active high) empties the queue, drops queued commands
//   and pending results, and sets ascending order. No clearing pass is needed.
// Back-pressure:
//   A stalled receiver holds the result register; the engine waits, the
//   command queue fills and in_ready drops once it is full.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_order_descending,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     command,
  input  logic [KEY_W-1:0]     entry_key,
  input  logic [PAYLOAD_W-1:0] entry_payload,
  input  logic [INDEX_W-1:0]   position_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic [KEY_W-1:0]     result_key,
  output logic [PAYLOAD_W-1:0] result_payload,
  output logic [POS_W-1:0]     insert_position,
  output logic [SIZE_W-1:0]    removed_count,
  output logic [SIZE_W-1:0]    queue_size
);

  logic order_descending;
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // Config register: accept every write, take effect on later offers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_descending <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      order_descending <= cfg_order_descending;
    end
  end

  // Decode commands at the input
  spq_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .entry_key      (entry_key),
    .entry_payload  (entry_payload),
    .position_index (position_index),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_cmd       (push_cmd)
  );

  // Buffer decoded commands so the input need not wait on a busy engine until the buffer fills
  spq_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Run each command, as one scan over the entry memory where it needs one
  spq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .order_descending (order_descending),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_cmd          (pop_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .result_key       (result_key),
    .result_payload   (result_payload),
    .insert_position  (insert_position),
    .removed_count    (removed_count),
    .queue_size       (queue_size)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the sorted priority queue: directed table, then random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 250;
  // One full scan plus setup and the command queue ahead of it.
  localparam int SETTLE_CYCLES = 3 * (DEPTH + 6);
  localparam int STALL_LIMIT  = 4000;
  localparam int REPORT_LIMIT = 10;

  // Command codes with no operation; the block answers them with status OK and no change.
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  // One result transaction, in port order.
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic [POS_W-1:0]     position;
    logic [SIZE_W-1:0]    removed;
    logic [SIZE_W-1:0]    size;
  } outcome_t;

  // One row of the directed table; reps issues the row several times, payload counting up.
  typedef struct {
    logic [CMD_W-1:0]     cmd;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic [INDEX_W-1:0]   idx;
    int                   reps;
    bit                   typed;
    outcome_t             want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_order_descending = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     command = CMD_OFFER;
  logic [KEY_W-1:0]     entry_key = '0;
  logic [PAYLOAD_W-1:0] entry_payload = '0;
  logic [INDEX_W-1:0]   position_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [KEY_W-1:0]     result_key;
  logic [PAYLOAD_W-1:0] result_payload;
  logic [POS_W-1:0]     insert_position;
  logic [SIZE_W-1:0]    removed_count;
  logic [SIZE_W-1:0]    queue_size;

  // Shadow copy of the queue contents and the order register.
  logic [KEY_W-1:0]     shadow_key [DEPTH];
  logic [PAYLOAD_W-1:0] shadow_payload [DEPTH];
  int                   held = 0;
  bit                   descending_order = 1'b0;

  outcome_t results_due[$];
  int       mismatches = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;
  int       stall_mode = 0;
  int       stall_run = 0;

  always #5 clk = ~clk;

  sorted_priority_queue dut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_order_descending (cfg_order_descending),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .command              (command),
    .entry_key            (entry_key),
    .entry_payload        (entry_payload),
    .position_index       (position_index),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .status               (status),
    .result_key           (result_key),
    .result_payload       (result_payload),
    .insert_position      (insert_position),
    .removed_count        (removed_count),
    .queue_size           (queue_size)
  );

  // Apply one command to the shadow queue and return the result it must produce.
  function automatic outcome_t predict_command(input logic [CMD_W-1:0] cmd,
                                               input logic [KEY_W-1:0] key,
                                               input logic [PAYLOAD_W-1:0] payload,
                                               input logic [INDEX_W-1:0] idx);
    outcome_t r;
    int       slot;
    int       kept;
    int       gone;
    r = '0;
    gone = -1;
    case (cmd)
      CMD_OFFER: begin
        if (held >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          // Walk past strictly better keys only, so a new entry lands ahead of equal keys.
          slot = 0;
          while (slot < held && (descending_order ? key < shadow_key[slot]
                                                  : key > shadow_key[slot]))
            slot++;
          for (int n = held; n > slot; n--) begin
            shadow_key[n]     = shadow_key[n - 1];
            shadow_payload[n] = shadow_payload[n - 1];
          end
          shadow_key[slot]     = key;
          shadow_payload[slot] = payload;
          held++;
          r.position = POS_W'(slot);
        end
      end
      CMD_PEEK, CMD_POLL: begin
        if (held == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.key     = shadow_key[0];
          r.payload = shadow_payload[0];
          if (cmd == CMD_POLL) gone = 0;
        end
      end
      CMD_READ, CMD_DROP_AT: begin
        if (int'(idx) >= held) begin
          r.status = STAT_RANGE;
        end else begin
          r.key     = shadow_key[idx];
          r.payload = shadow_payload[idx];
          if (cmd == CMD_DROP_AT) gone = int'(idx);
        end
      end
      CMD_MATCH: begin
        // Compact the survivors toward the head, keeping their order.
        kept = 0;
        for (int n = 0; n < held; n++) begin
          if (shadow_key[n] == key) begin
            r.removed++;
          end else begin
            shadow_key[kept]     = shadow_key[n];
            shadow_payload[kept] = shadow_payload[n];
            kept++;
          end
        end
        held = kept;
      end
      default: ;
    endcase
    // Close the hole left by a poll or a remove-at.
    if (gone >= 0) begin
      for (int n = gone; n + 1 < held; n++) begin
        shadow_key[n]     = shadow_key[n + 1];
        shadow_payload[n] = shadow_payload[n + 1];
      end
      held--;
    end
    r.size = SIZE_W'(held);
    return r;
  endfunction

  function automatic plan_row_t row(input logic [CMD_W-1:0] cmd,
                                    input logic [KEY_W-1:0] key,
                                    input logic [PAYLOAD_W-1:0] payload,
                                    input logic [INDEX_W-1:0] idx,
                                    input int reps = 1,
                                    input bit typed = 1'b0,
                                    input outcome_t want = '0);
    plan_row_t p;
    p.cmd     = cmd;
    p.key     = key;
    p.payload = payload;
    p.idx     = idx;
    p.reps    = reps;
    p.typed   = typed;
    p.want    = want;
    return p;
  endfunction

  // Issue one command transaction, opening a new burst (and maybe a gap) when the last one ran out.
  // A typed expectation replaces the prediction, but the shadow queue still advances.
  task automatic send_command(input logic [CMD_W-1:0] cmd,
                              input logic [KEY_W-1:0] key,
                              input logic [PAYLOAD_W-1:0] payload,
                              input logic [INDEX_W-1:0] idx,
                              input bit typed,
                              input outcome_t want);
    outcome_t due;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    command        <= cmd;
    entry_key      <= key;
    entry_payload  <= payload;
    position_index <= idx;
    do @(posedge clk); while (!in_ready);
    due = predict_command(cmd, key, payload, idx);
    if (typed) due = want;
    results_due.push_back(due);
  endtask

  // Drop valid and hold until every outstanding result has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Write the order register; call only with the block idle.
  task automatic load_order(input bit descending);
    cfg_valid            <= 1'b1;
    cfg_order_descending <= descending;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid        <= 1'b0;
    descending_order = descending;
  endtask

  // Receiver: alternate between open, coin-flip, mostly-open and fully stalled stretches.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = (stall_mode == 3) ? $urandom_range(1, 40) : $urandom_range(8, 60);
    end
    stall_run--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 5) != 0);
      default: out_ready <= 1'b0;
    endcase
  end

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t due;
    if (!rst && out_valid && out_ready) begin
      got = '{status, result_key, result_payload, insert_position, removed_count, queue_size};
      if (results_due.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: result with no command outstanding: status=%0d key=%h size=%0d",
                   $realtime, got.status, got.key, got.size);
        mismatches++;
      end else begin
        due = results_due.pop_front();
        if (got.status !== due.status || got.key !== due.key ||
            got.payload !== due.payload || got.position !== due.position ||
            got.removed !== due.removed || got.size !== due.size) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("%0t: mismatch  expected status=%0d key=%h payload=%h pos=%0d removed=%0d size=%0d",
                     $realtime, due.status, due.key, due.payload, due.position, due.removed,
                     due.size);
            $display("%0t:           actual   status=%0d key=%h payload=%h pos=%0d removed=%0d size=%0d",
                     $realtime, got.status, got.key, got.payload, got.position, got.removed,
                     got.size);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: give up once no transaction of any kind has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    plan_row_t        plan[$];
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [INDEX_W-1:0] idx;
    int               issued;
    int               run_left;
    int               offer_pct;

    // Directed table, ascending order from reset. Typed rows are the empty queue,
    // the spare command, the first offers, the full queue and the remove-everything match.
    plan.push_back(row(CMD_PEEK, 16'h0, 32'h0, 4'd0, 1, 1'b1,
                       outcome_t'{STAT_EMPTY, 16'h0, 32'h0, 4'd0, 5'd0, 5'd0}));
    plan.push_back(row(CMD_POLL, 16'h0, 32'h0, 4'd0, 1, 1'b1,
                       outcome_t'{STAT_EMPTY, 16'h0, 32'h0, 4'd0, 5'd0, 5'd0}));
    plan.push_back(row(CMD_READ, 16'h0, 32'h0, 4'd0, 1, 1'b1,
                       outcome_t'{STAT_RANGE, 16'h0, 32'h0, 4'd0, 5'd0, 5'd0}));
    plan.push_back(row(CMD_DROP_AT, 16'h0, 32'h0, 4'd15, 1, 1'b1,
                       outcome_t'{STAT_RANGE, 16'h0, 32'h0, 4'd0, 5'd0, 5'd0}));
    plan.push_back(row(CMD_MATCH, 16'hFFFF, 32'h0, 4'd0, 1, 1'b1,
                       outcome_t'{STAT_OK, 16'h0, 32'h0, 4'd0, 5'd0, 5'd0}));
    plan.push_back(row(CMD_SPARE_7, 16'hFFFF, 32'hFFFF_FFFF, 4'd15, 1, 1'b1,
                       outcome_t'{STAT_OK, 16'h0, 32'h0, 4'd0, 5'd0, 5'd0}));
    plan.push_back(row(CMD_OFFER, 16'hFFFF, 32'hFFFF_FFFF, 4'd0, 1, 1'b1,
                       outcome_t'{STAT_OK, 16'h0, 32'h0, 4'd0, 5'd0, 5'd1}));
    plan.push_back(row(CMD_OFFER, 16'h0000, 32'h0000_0000, 4'd0, 1, 1'b1,
                       outcome_t'{STAT_OK, 16'h0, 32'h0, 4'd0, 5'd0, 5'd2}));
    // Equal keys: the second offer must land ahead of the first.
    plan.push_back(row(CMD_OFFER, 16'h8000, 32'hA5A5_A5A5, 4'd0));
    plan.push_back(row(CMD_OFFER, 16'h8000, 32'h5A5A_5A5A, 4'd0));
    plan.push_back(row(CMD_PEEK, 16'h0, 32'h0, 4'd0));
    plan.push_back(row(CMD_READ, 16'h0, 32'h0, 4'd2));
    plan.push_back(row(CMD_DROP_AT, 16'h0, 32'h0, 4'd1));
    plan.push_back(row(CMD_MATCH, 16'h8000, 32'h0, 4'd0));
    plan.push_back(row(CMD_POLL, 16'h0, 32'h0, 4'd0));
    plan.push_back(row(CMD_DROP_AT, 16'h0, 32'h0, 4'd0));
    // Fill to the brim with one key, get refused, then clear it all with one match.
    plan.push_back(row(CMD_OFFER, 16'h1234, 32'hC0DE_0000, 4'd0, DEPTH));
    plan.push_back(row(CMD_OFFER, 16'hBEEF, 32'h1, 4'd0, 1, 1'b1,
                       outcome_t'{STAT_FULL, 16'h0, 32'h0, 4'd0, 5'd0, 5'd16}));
    plan.push_back(row(CMD_READ, 16'h0, 32'h0, 4'd15));
    plan.push_back(row(CMD_MATCH, 16'h1234, 32'h0, 4'd0, 1, 1'b1,
                       outcome_t'{STAT_OK, 16'h0, 32'h0, 4'd0, 5'd16, 5'd0}));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r])
      for (int k = 0; k < plan[r].reps; k++)
        send_command(plan[r].cmd, plan[r].key, plan[r].payload + k, plan[r].idx,
                     plan[r].typed, plan[r].want);

    // Random phases. Each starts idle and loads an order setting; entries held over
    // from the last phase stay where they are when the order flips.
    offer_pct = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      load_order(phase == 0 ? 1'b1 : phase == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
      issued   = 0;
      run_left = 0;
      while (issued < PHASE_ITEMS) begin
        // Swing between filling and emptying runs so full and empty both come up often.
        if (run_left == 0) begin
          run_left  = $urandom_range(10, 40);
          offer_pct = (offer_pct >= 50) ? $urandom_range(0, 10) : $urandom_range(75, 90);
        end
        run_left--;
        if ($urandom_range(0, 99) < offer_pct) begin
          cmd = CMD_OFFER;
        end else begin
          case ($urandom_range(0, 9))
            0, 1:    cmd = CMD_PEEK;
            2, 3:    cmd = CMD_POLL;
            4, 5:    cmd = CMD_READ;
            6:       cmd = CMD_MATCH;
            7, 8:    cmd = CMD_DROP_AT;
            default: cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
          endcase
        end
        // Mix a small key pool, full-range keys, extremes and keys already held.
        case ($urandom_range(0, 3))
          0: key = KEY_W'($urandom_range(0, 7));
          1: key = KEY_W'($urandom());
          2: key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: key = (held > 0) ? shadow_key[$urandom_range(0, held - 1)]
                                    : KEY_W'($urandom());
        endcase
        idx = (held > 0 && $urandom_range(0, 3) != 0) ? INDEX_W'($urandom_range(0, held - 1))
                                                      : INDEX_W'($urandom_range(0, 15));
        send_command(cmd, key, $urandom(), idx, 1'b0, '0);
        if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7) issued++;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_front.sv
hdl/spq_fifo.sv
hdl/spq_back.sv
hdl/sorted_priority_queue.sv
verif/testbench.sv
